[hdl/derp_pkg.sv]
// Package for the digitizer event record parser.
// Holds the word class codes, the segment descriptor type and the header block sizes.
// No dependencies.
package derp_pkg;

   // Word class codes; also used as the parser's segment kind
   typedef enum logic [3:0] {
      KIND_REC    = 4'd0,
      KIND_START  = 4'd1,
      KIND_HDR0   = 4'd2,
      KIND_HDR1   = 4'd3,
      KIND_HDR2   = 4'd4,
      KIND_HDR3   = 4'd5,
      KIND_WFLEN  = 4'd6,
      KIND_AVELEN = 4'd7,
      KIND_WF     = 4'd8,
      KIND_AVE    = 4'd9,
      KIND_MAW    = 4'd10,
      KIND_DISC   = 4'd11
   } kind_type;

   // Latched error codes
   typedef enum logic [1:0] {
      ERR_NONE   = 2'd0,
      ERR_HDRLEN = 2'd1,
      ERR_WFLEN  = 2'd2
   } err_type;

   localparam int CNT_W   = 26;
   localparam int IDX_W   = 7;
   localparam int EVN_W   = 16;
   localparam int AVE_W   = 16;
   localparam int WORD_W  = 32;
   localparam int FLAG_W  = 4;
   localparam int DATA_W  = 32;
   localparam int RSP_W   = 48;

   localparam logic [CNT_W-1:0]  CNT_MAX     = 26'h3ffffff;
   localparam logic [EVN_W-1:0]  EVN_MAX     = 16'hffff;
   localparam logic [WORD_W-1:0] WFLEN_MASK  = 32'h2ffffff;
   localparam logic [3:0]        AVE_TAG     = 4'ha;
   localparam logic [CNT_W-1:0]  START_WORDS = 26'd2;

   // Optional header block sizes, in words
   localparam logic [CNT_W-1:0] BLOCK_SIZE [4] = '{26'd7, 26'd2, 26'd3, 26'd2};

   // Segment descriptor: kind plus words left in it
   typedef struct packed {
      kind_type         kind;
      logic [CNT_W-1:0] rem;
   } seg_type;

   // First enabled header block at or after position from, else the waveform length word
   function automatic seg_type next_block(input logic [FLAG_W-1:0] flags,
                                          input logic [2:0] from);
      seg_type r;
      logic    found;
      r.kind = KIND_WFLEN;
      r.rem  = '0;
      found  = 1'b0;
      for (int i = 0; i < 4; i++) begin
         if (!found && (3'(i) >= from) && flags[i]) begin
            found  = 1'b1;
            r.kind = kind_type'(4'(KIND_HDR0) + 4'(i));
            r.rem  = BLOCK_SIZE[i];
         end
      end
      return r;
   endfunction

endpackage

[hdl/digitizer_event_record_parser.sv]
// Digitizer event record parser: labels each 32-bit record word with its class.
// Depends on derp_pkg.
//
//  channel | direction | tdata                               | tuser      | tlast
//  req     | in        | data_word[31:0]                     | -          | last_in_record
//  rsp     | out       | event_number[15:0],                 | word_class | event_done
//          |           | word_in_event[41:16], error_code[43:42]
//
// One word per clock sustained while rsp is not stalled; a word passes through the input
// register, then one pass of parse logic into the result register.
// The parse state updates once per word in that single pass, so words follow back to back.
// Reset is synchronous and active high; it clears control and parse state.
// A stall on rsp holds the result register; the next word waits in the input register and
// req_tready drops in that same cycle.
module digitizer_event_record_parser #(
   parameter int RECORD_HEADER_WORDS = 10
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [derp_pkg::DATA_W-1:0] req_tdata,   // [31:0] data_word
   input  logic                       req_tlast,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [derp_pkg::RSP_W-1:0] rsp_tdata,   // [15:0] event_number,
                                                   // [41:16] word_in_event,
                                                   // [43:42] error_code, rest zero
   output logic [3:0]                 rsp_tuser,   // [3:0] word_class
   output logic                       rsp_tlast    // event_done
);
   import derp_pkg::*;

   // Input register
   logic              in_valid_ff, in_valid_in;
   logic [WORD_W-1:0] in_data_ff;
   logic              in_last_ff;

   // Result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]  rsp_data_ff, rsp_data_in;
   logic [3:0]        rsp_user_ff, rsp_user_in;
   logic              rsp_last_ff, rsp_last_in;

   // Parse state
   logic [IDX_W-1:0]  rec_idx_ff, rec_idx_in;
   logic [WORD_W-1:0] event_len_ff, event_len_in;
   logic [WORD_W-1:0] exp_hdr_len_ff, exp_hdr_len_in;
   logic [CNT_W-1:0]  word_count_ff, word_count_in;
   logic [FLAG_W-1:0] flags_ff, flags_in;
   kind_type          kind_ff, kind_in;
   logic [CNT_W-1:0]  seg_rem_ff, seg_rem_in;
   logic [AVE_W-1:0]  ave_len_ff, ave_len_in;
   logic              maw_ff, maw_in;
   err_type           error_ff, error_in;
   logic [EVN_W-1:0]  event_cnt_ff, event_cnt_in;

   logic              advance;
   logic              req_xfer;

   // Parse temporaries
   kind_type          cls;
   logic [EVN_W-1:0]  evn;
   logic [CNT_W-1:0]  wie;
   logic              done;
   logic              hc_go, aw_go, tl_go, fin;
   logic [CNT_W-1:0]  hc_len;
   logic [CNT_W-1:0]  maw_limit;
   logic [WORD_W-1:0] wf_masked;
   seg_type           nb;

   // Handshake and pipeline advance
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_xfer   = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   always_comb begin
      if (req_xfer) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Parse one word: next state and result fields
   always_comb begin
      rec_idx_in     = rec_idx_ff;
      event_len_in   = event_len_ff;
      exp_hdr_len_in = exp_hdr_len_ff;
      word_count_in  = word_count_ff;
      flags_in       = flags_ff;
      kind_in        = kind_ff;
      seg_rem_in     = seg_rem_ff;
      ave_len_in     = ave_len_ff;
      maw_in         = maw_ff;
      error_in       = error_ff;
      event_cnt_in   = event_cnt_ff;

      cls       = kind_ff;
      evn       = '0;
      wie       = '0;
      done      = 1'b0;
      hc_go     = 1'b0;
      aw_go     = 1'b0;
      tl_go     = 1'b0;
      fin       = 1'b0;
      hc_len    = '0;
      wf_masked = in_data_ff & WFLEN_MASK;
      nb        = next_block(flags_ff, 3'd0);
      maw_limit = (event_len_ff > 32'(CNT_MAX)) ? CNT_MAX : event_len_ff[CNT_W-1:0];

      if (kind_ff == KIND_REC) begin
         // record header words
         if (rec_idx_ff == 7'd3) begin
            event_len_in = in_data_ff;
         end
         if (rec_idx_ff == 7'd5) begin
            exp_hdr_len_in = in_data_ff;
         end
         rec_idx_in = rec_idx_ff + 7'd1;
         if (rec_idx_in >= IDX_W'(RECORD_HEADER_WORDS)) begin
            kind_in       = KIND_START;
            seg_rem_in    = START_WORDS;
            word_count_in = '0;
            flags_in      = '0;
            ave_len_in    = '0;
            maw_in        = 1'b0;
         end
      end else if (kind_ff == KIND_DISC) begin
         evn = event_cnt_ff;
      end else begin
         evn = event_cnt_ff;
         wie = word_count_ff;
         if (word_count_ff < CNT_MAX) begin
            word_count_in = word_count_ff + 26'd1;
         end
         case (kind_ff)
            KIND_START: begin
               if (seg_rem_ff == START_WORDS) begin
                  flags_in = in_data_ff[FLAG_W-1:0];
               end
               seg_rem_in = seg_rem_ff - 26'd1;
               if (seg_rem_in == '0) begin
                  kind_in    = nb.kind;
                  seg_rem_in = nb.rem;
               end
            end
            KIND_HDR0, KIND_HDR1, KIND_HDR2, KIND_HDR3: begin
               if (seg_rem_ff != '0) begin
                  seg_rem_in = seg_rem_ff - 26'd1;
               end
               if (seg_rem_in == '0) begin
                  nb         = next_block(flags_ff, 3'(kind_ff - KIND_HDR0) + 3'd1);
                  kind_in    = nb.kind;
                  seg_rem_in = nb.rem;
               end
            end
            KIND_WFLEN: begin
               maw_in     = in_data_ff[27];
               ave_len_in = '0;
               if (in_data_ff[31:28] == AVE_TAG) begin
                  kind_in    = KIND_AVELEN;
                  seg_rem_in = wf_masked[CNT_W-1:0];
               end else begin
                  hc_go  = 1'b1;
                  hc_len = wf_masked[CNT_W-1:0];
               end
            end
            KIND_AVELEN: begin
               ave_len_in = in_data_ff[AVE_W-1:0];
               hc_go      = 1'b1;
               hc_len     = seg_rem_ff;
            end
            KIND_WF: begin
               seg_rem_in = seg_rem_ff - 26'd1;
               aw_go      = (seg_rem_in == '0);
            end
            KIND_AVE: begin
               seg_rem_in = seg_rem_ff - 26'd1;
               tl_go      = (seg_rem_in == '0);
            end
            KIND_MAW: begin
               tl_go = 1'b1;
            end
            default: begin
            end
         endcase

         // header length check at the end of the event header
         if (hc_go) begin
            if (32'(word_count_in) != exp_hdr_len_ff) begin
               error_in   = ERR_HDRLEN;
               kind_in    = KIND_DISC;
               seg_rem_in = '0;
            end else if (hc_len != '0) begin
               kind_in    = KIND_WF;
               seg_rem_in = hc_len;
            end else begin
               aw_go = 1'b1;
            end
         end

         // after raw samples: averaged samples, or straight to the tail
         if (aw_go) begin
            if (ave_len_in != '0) begin
               kind_in    = KIND_AVE;
               seg_rem_in = CNT_W'(ave_len_in);
            end else begin
               tl_go = 1'b1;
            end
         end

         // event tail: MAW words or exact length check
         if (tl_go) begin
            if (maw_in) begin
               if (word_count_in >= maw_limit) begin
                  fin = 1'b1;
               end else begin
                  kind_in    = KIND_MAW;
                  seg_rem_in = '0;
               end
            end else if (32'(word_count_in) == event_len_ff) begin
               fin = 1'b1;
            end else begin
               error_in   = ERR_WFLEN;
               kind_in    = KIND_DISC;
               seg_rem_in = '0;
            end
         end

         // event complete: count it and open the next one
         if (fin) begin
            done = 1'b1;
            if (event_cnt_ff < EVN_MAX) begin
               event_cnt_in = event_cnt_ff + 16'd1;
            end
            kind_in       = KIND_START;
            seg_rem_in    = START_WORDS;
            word_count_in = '0;
            flags_in      = '0;
            ave_len_in    = '0;
            maw_in        = 1'b0;
         end
      end

      rsp_user_in = cls;
      rsp_last_in = done;
      rsp_data_in = {4'd0, error_in, wie, evn};

      // end of record: back to the reset state
      if (in_last_ff) begin
         rec_idx_in     = '0;
         event_len_in   = '0;
         exp_hdr_len_in = '0;
         word_count_in  = '0;
         flags_in       = '0;
         kind_in        = KIND_REC;
         seg_rem_in     = '0;
         ave_len_in     = '0;
         maw_in         = 1'b0;
         error_in       = ERR_NONE;
         event_cnt_in   = '0;
      end
   end

   // Control and parse state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         rec_idx_ff     <= '0;
         event_len_ff   <= '0;
         exp_hdr_len_ff <= '0;
         word_count_ff  <= '0;
         flags_ff       <= '0;
         kind_ff        <= KIND_REC;
         seg_rem_ff     <= '0;
         ave_len_ff     <= '0;
         maw_ff         <= 1'b0;
         error_ff       <= ERR_NONE;
         event_cnt_ff   <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            rec_idx_ff     <= rec_idx_in;
            event_len_ff   <= event_len_in;
            exp_hdr_len_ff <= exp_hdr_len_in;
            word_count_ff  <= word_count_in;
            flags_ff       <= flags_in;
            kind_ff        <= kind_in;
            seg_rem_ff     <= seg_rem_in;
            ave_len_ff     <= ave_len_in;
            maw_ff         <= maw_in;
            error_ff       <= error_in;
            event_cnt_ff   <= event_cnt_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_data_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

endmodule

[test/testbench.sv]
// Testbench for digitizer_event_record_parser: streams record words, predicts each word's
// label with a cycle-free model of the parser and checks every result transfer in order.
// Depends on derp_pkg and the parser RTL.
`timescale 1ns / 1ps

module testbench;
   import derp_pkg::*;

   localparam int          CLK_PERIOD         = 10;
   localparam int          HDR_WORDS          = 10;
   localparam int          EVLEN_WORD         = 3;
   localparam int          HDRLEN_WORD        = 5;
   localparam int          RANDOM_WORD_TARGET = 1400;
   localparam int          GAPFREE_WORDS      = 300;
   localparam int          DRAIN_CYCLES       = 16;
   localparam int          HOLD_AFTER_RESULTS = 200;
   localparam int          HOLD_CYCLES        = 400;
   // Slowest correct run: ~2k words, each after the longest idle gap, plus the longest stall
   // on each result and one long hold.
   localparam int unsigned CYCLE_LIMIT        = 600000;
   localparam int          HDR_BLOCK_WORDS[4] = '{7, 2, 3, 2};

   // Expected label of one word
   typedef struct packed {
      kind_type         cls;
      logic [EVN_W-1:0] evn;
      logic [CNT_W-1:0] wie;
      logic             done;
      err_type          err;
   } word_label_type;

   // Parser state mirror plus the queue of labels still to come out
   class label_scoreboard_type;
      int               hdr_words;
      int               block_words[4];
      logic [IDX_W-1:0] rec_idx;
      logic [31:0]      ev_len;
      logic [31:0]      exp_hdr;
      logic [CNT_W-1:0] word_cnt;
      logic [3:0]       flags;
      kind_type         seg_kind;
      logic [CNT_W-1:0] seg_rem;
      logic [AVE_W-1:0] ave_len;
      logic             maw;
      err_type          err;
      logic [EVN_W-1:0] ev_cnt;
      word_label_type   labels_due[$];
      int unsigned      mismatches;

      function new(int hdr_words);
         this.hdr_words = hdr_words;
         block_words    = '{7, 2, 3, 2};
         mismatches     = 0;
         clear();
      endfunction

      function void clear();
         rec_idx  = '0;
         ev_len   = '0;
         exp_hdr  = '0;
         word_cnt = '0;
         flags    = '0;
         seg_kind = KIND_REC;
         seg_rem  = '0;
         ave_len  = '0;
         maw      = 1'b0;
         err      = ERR_NONE;
         ev_cnt   = '0;
      endfunction

      function void start_event();
         seg_kind = KIND_START;
         seg_rem  = START_WORDS;
         word_cnt = '0;
         flags    = '0;
         ave_len  = '0;
         maw      = 1'b0;
      endfunction

      function bit close_event();
         if (ev_cnt != EVN_MAX) ev_cnt++;
         start_event();
         return 1'b1;
      endfunction

      function void latch_error(err_type code);
         err      = code;
         seg_kind = KIND_DISC;
         seg_rem  = '0;
      endfunction

      // first enabled header block at or after position from
      function void seek_block(int from);
         for (int i = from; i < 4; i++) begin
            if (flags[i]) begin
               seg_kind = kind_type'(4'(int'(KIND_HDR0) + i));
               seg_rem  = CNT_W'(block_words[i]);
               return;
            end
         end
         seg_kind = KIND_WFLEN;
         seg_rem  = '0;
      endfunction

      function bit run_tail();
         logic [CNT_W-1:0] lim;
         if (maw) begin
            lim = (ev_len > 32'(CNT_MAX)) ? CNT_MAX : ev_len[CNT_W-1:0];
            if (word_cnt >= lim) return close_event();
            seg_kind = KIND_MAW;
            seg_rem  = '0;
            return 1'b0;
         end
         if (32'(word_cnt) == ev_len) return close_event();
         latch_error(ERR_WFLEN);
         return 1'b0;
      endfunction

      function bit after_samples();
         if (ave_len != 0) begin
            seg_kind = KIND_AVE;
            seg_rem  = CNT_W'(ave_len);
            return 1'b0;
         end
         return run_tail();
      endfunction

      function bit check_header(logic [CNT_W-1:0] wf_len);
         if (32'(word_cnt) != exp_hdr) begin
            latch_error(ERR_HDRLEN);
            return 1'b0;
         end
         if (wf_len != 0) begin
            seg_kind = KIND_WF;
            seg_rem  = wf_len;
            return 1'b0;
         end
         return after_samples();
      endfunction

      // accepted input word: work out its label, advance the mirror
      function void note_word(logic [31:0] w, logic last);
         word_label_type e;
         e.cls  = seg_kind;
         e.evn  = '0;
         e.wie  = '0;
         e.done = 1'b0;
         if (seg_kind == KIND_REC) begin
            if (rec_idx == EVLEN_WORD) ev_len = w;
            if (rec_idx == HDRLEN_WORD) exp_hdr = w;
            rec_idx++;
            if (rec_idx >= hdr_words) start_event();
         end else if (seg_kind == KIND_DISC) begin
            e.evn = ev_cnt;
         end else begin
            e.evn = ev_cnt;
            e.wie = word_cnt;
            if (word_cnt != CNT_MAX) word_cnt++;
            case (seg_kind)
               KIND_START: begin
                  if (seg_rem == START_WORDS) flags = w[3:0];
                  seg_rem--;
                  if (seg_rem == 0) seek_block(0);
               end
               KIND_WFLEN: begin
                  maw     = w[27];
                  ave_len = '0;
                  if (w[31:28] == AVE_TAG) begin
                     seg_kind = KIND_AVELEN;
                     seg_rem  = CNT_W'(w & WFLEN_MASK);
                  end else begin
                     e.done = check_header(CNT_W'(w & WFLEN_MASK));
                  end
               end
               KIND_AVELEN: begin
                  ave_len = w[AVE_W-1:0];
                  e.done  = check_header(seg_rem);
               end
               KIND_WF: begin
                  seg_rem--;
                  if (seg_rem == 0) e.done = after_samples();
               end
               KIND_AVE: begin
                  seg_rem--;
                  if (seg_rem == 0) e.done = run_tail();
               end
               KIND_MAW: e.done = run_tail();
               default: begin
                  // optional header blocks
                  if (seg_rem != 0) seg_rem--;
                  if (seg_rem == 0) seek_block(int'(seg_kind) - int'(KIND_HDR0) + 1);
               end
            endcase
         end
         e.err = err;
         labels_due.push_back(e);
         if (last) clear();
      endfunction

      task report(string msg);
         if (mismatches < 40) $display("mismatch: %s", msg);
         mismatches++;
      endtask

      function int pending();
         return labels_due.size();
      endfunction

      task check_result(logic [RSP_W-1:0] tdata, logic [3:0] tuser, logic tlast);
         word_label_type e;
         if (labels_due.size() == 0) begin
            report($sformatf("result with no word pending, tdata %0h", tdata));
            return;
         end
         e = labels_due.pop_front();
         if (tuser !== e.cls)
            report($sformatf("word_class %0d, want %0d", tuser, e.cls));
         if (tdata[15:0] !== e.evn)
            report($sformatf("event_number %0h, want %0h", tdata[15:0], e.evn));
         if (tdata[41:16] !== e.wie)
            report($sformatf("word_in_event %0h, want %0h", tdata[41:16], e.wie));
         if (tlast !== e.done)
            report($sformatf("event_done %0b, want %0b", tlast, e.done));
         if (tdata[43:42] !== e.err)
            report($sformatf("error_code %0d, want %0d", tdata[43:42], e.err));
         if (tdata[RSP_W-1:44] !== '0)
            report($sformatf("pad bits %0h not zero", tdata[RSP_W-1:44]));
      endtask
   endclass

   logic               clock      = 1'b0;
   logic               reset      = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [DATA_W-1:0]  req_tdata  = '0;
   logic               req_tlast  = 1'b0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [RSP_W-1:0]   rsp_tdata;
   logic [3:0]         rsp_tuser;
   logic               rsp_tlast;

   label_scoreboard_type sb;
   bit                   src_idle   = 1'b1;
   bit                   sink_idle  = 1'b1;
   int                   words_sent = 0;

   digitizer_event_record_parser #(
      .RECORD_HEADER_WORDS(HDR_WORDS)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // mostly short gaps, a few long ones
   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic int hdr_block_sum(logic [3:0] fl);
      int s;
      s = 0;
      for (int i = 0; i < 4; i++) if (fl[i]) s += HDR_BLOCK_WORDS[i];
      return s;
   endfunction

   task automatic send_word(input logic [31:0] w, input logic last);
      int gap;
      gap = src_idle ? idle_gap() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= w;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      sb.note_word(w, last);
      words_sent++;
   endtask

   task automatic send_record(ref logic [31:0] q[$]);
      foreach (q[i]) send_word(q[i], i == q.size() - 1);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // one event: start words, header blocks, length words, samples, MAW words
   function automatic void add_event(ref logic [31:0] q[$], input logic [3:0] fl,
                                     input int wf, input bit ave_on, input int ave,
                                     input bit maw_on, input int maw_n);
      logic [31:0] lw;
      q.push_back({28'($urandom()), fl});
      q.push_back($urandom());
      repeat (hdr_block_sum(fl)) q.push_back($urandom());
      lw        = $urandom();
      lw[25]    = 1'b0;
      lw[23:0]  = 24'(wf);
      lw[27]    = maw_on;
      if (ave_on) lw[31:28] = AVE_TAG;
      else if (lw[31:28] == AVE_TAG) lw[31:28] = ~AVE_TAG;
      q.push_back(lw);
      if (ave_on) q.push_back({16'($urandom()), 16'(ave)});
      repeat (wf + ave + maw_n) q.push_back($urandom());
   endfunction

   // mostly consistent records with random content; some broken, cut short or pure noise
   task automatic random_record();
      logic [31:0] q[$];
      logic [31:0] ev_len, hl;
      logic [3:0]  fl, efl, cand;
      bit          ave_on, maw_on;
      int          mode, hdr_len, body, wf, ave, maw_n, cut;
      mode   = $urandom_range(0, 99);
      fl     = 4'($urandom());
      ave_on = 1'($urandom_range(0, 1));
      maw_on = $urandom_range(0, 2) == 0;
      hdr_len = 3 + hdr_block_sum(fl) + int'(ave_on);
      body    = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 120) : $urandom_range(0, 20);
      ev_len  = hdr_len + body;
      hl      = hdr_len;
      if (mode < 8) ev_len = $urandom_range(0, 1) ? ev_len + 1 : ev_len - 1;
      else if (mode < 14) hl = $urandom_range(0, 1) ? hl + 1 : hl - 1;
      else if (mode < 18) ev_len = $urandom();
      else if (mode >= 94) begin
         ev_len = $urandom();
         hl     = $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 20);
      end
      for (int i = 0; i < HDR_WORDS; i++)
         q.push_back(i == EVLEN_WORD ? ev_len : i == HDRLEN_WORD ? hl : $urandom());
      if (mode >= 94) begin
         repeat ($urandom_range(1, 30)) q.push_back($urandom());
      end else begin
         repeat ($urandom_range(1, 5)) begin
            // flags may change between events if the header length stays the same
            efl = fl;
            repeat (8) begin
               cand = 4'($urandom());
               if (hdr_block_sum(cand) == hdr_block_sum(fl)) efl = cand;
            end
            ave   = ave_on ? $urandom_range(0, body) : 0;
            wf    = maw_on ? $urandom_range(0, body - ave) : body - ave;
            maw_n = maw_on ? body - wf - ave : 0;
            if (maw_on && $urandom_range(0, 3) == 0) begin
               // samples overrun the event length: event closes at the last sample
               wf    = wf + maw_n + $urandom_range(1, 3);
               maw_n = 0;
            end
            add_event(q, efl, wf, ave_on, ave, maw_on, maw_n);
         end
      end
      if (mode >= 18 && mode < 30) begin
         cut = $urandom_range(1, q.size());
         while (q.size() > cut) void'(q.pop_back());
      end else if (mode >= 30 && mode < 36) begin
         repeat ($urandom_range(1, 15)) q.push_back($urandom());
      end
      send_record(q);
   endtask

   // result side: random stalls, quiet stretches, one long hold
   initial begin : result_sink
      int  stall_left;
      int  seen;
      int  cyc;
      bit  held;
      bit  calm;
      stall_left = 0;
      seen       = 0;
      cyc        = 0;
      held       = 1'b0;
      calm       = 1'b0;
      forever begin
         @(posedge clock);
         cyc++;
         if (rsp_tvalid && rsp_tready) begin
            sb.check_result(rsp_tdata, rsp_tuser, rsp_tlast);
            seen++;
         end
         if (cyc % 300 == 0) calm = $urandom_range(0, 3) == 0;
         if (!held && seen >= HOLD_AFTER_RESULTS) begin
            held       = 1'b1;
            stall_left = HOLD_CYCLES;
         end else if (stall_left == 0 && sink_idle && !calm) begin
            stall_left = idle_gap();
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("FAIL digitizer_event_record_parser");
      $finish;
   end

   initial begin : stimulus
      logic [31:0] q[$];
      sb = new(HDR_WORDS);
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: two empty events ending on the length word, then a header cut short
      for (int i = 0; i < HDR_WORDS; i++)
         q.push_back(i == EVLEN_WORD || i == HDRLEN_WORD ? 32'd3 :
                     i[0] ? 32'h0000_0000 : 32'hffff_ffff);
      q.push_back(32'h0000_0000);
      q.push_back(32'hffff_ffff);
      q.push_back(32'h0000_0000);
      q.push_back(32'hffff_fff0);
      q.push_back(32'h0000_0000);
      q.push_back(32'hf500_0000);
      send_record(q);
      q = {32'hffff_ffff, 32'h0000_0000, 32'hffff_ffff};
      send_record(q);

      // random records, idling switched off now and then
      while (words_sent < RANDOM_WORD_TARGET - GAPFREE_WORDS) begin
         src_idle = $urandom_range(0, 3) != 0;
         random_record();
      end

      // sender waits for every result, then a gap-free stretch of random records
      wait_drained();
      src_idle  = 1'b0;
      sink_idle = 1'b0;
      while (words_sent < RANDOM_WORD_TARGET) random_record();

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("PASS digitizer_event_record_parser");
      else
         $display("FAIL digitizer_event_record_parser");
      $finish;
   end

endmodule

[files.f]
hdl/derp_pkg.sv
hdl/digitizer_event_record_parser.sv
test/testbench.sv
